// ===== sv/lbcp_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block cache policy package
// Shared sizes, codes and the structures passed between the slot cells.
// ----------------------------------------------------------------------------
package lbcp_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int ADDR_BITS = 32;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int RANK_W    = $clog2(NUM_SLOTS + 1);
   localparam int CAP_W     = 7;
   localparam int PSLOT_W   = 6;
   localparam int OUT_SLOT_W = 6;
   localparam int OUT_ADDR_W = 32;
   localparam int CAP_RESET  = 64;

   typedef enum logic [1:0] {
      MODE_MAP     = 2'd0,
      MODE_MIGRATE = 2'd1,
      MODE_REMOVE  = 2'd2,
      MODE_PRELOAD = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_HIT     = 3'd0,
      OP_NEW     = 3'd1,
      OP_REPLACE = 3'd2,
      OP_FAIL    = 3'd3,
      OP_NONE    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_TOUCH,
      ACT_HIT_MIG,
      ACT_NEW,
      ACT_REPLACE,
      ACT_MIGRATE,
      ACT_REMOVE,
      ACT_PRELOAD
   } act_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC
   } state_type;

   // Accumulated along the row of cells during the match cycle.
   typedef struct packed {
      logic                 hit;
      logic                 hit_mig;
      logic [RANK_W-1:0]    hit_rank;
      logic [SLOT_W-1:0]    hit_slot;
      logic [ADDR_BITS-1:0] victim_tag;
      logic                 victim_dirty;
      logic                 pre_busy;
      logic                 free_seen;
      logic [SLOT_W-1:0]    free_slot;
      logic                 rep_seen;
      logic [SLOT_W-1:0]    rep_slot;
   } chain_type;

   // Broadcast to every cell during the update cycle.
   typedef struct packed {
      act_type              act;
      logic [ADDR_BITS-1:0] addr;
      logic                 wr;
      logic [RANK_W-1:0]    push_rank;
      logic                 dec_en;
      logic [RANK_W-1:0]    dec_thr;
   } cmd_type;

endpackage

// ===== sv/lbcp_cell.sv =====
// ----------------------------------------------------------------------------
// LRU block cache policy slot cell
// Holds one slot's tag, flags and recency rank, and extends the match chain.
// ----------------------------------------------------------------------------
module lbcp_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lbcp_pkg::SLOT_W-1:0]    idx,
   input  logic [lbcp_pkg::ADDR_BITS-1:0] addr,
   input  logic [lbcp_pkg::PSLOT_W-1:0]   pslot,
   input  logic                           match_en,
   input  logic                           exec_en,
   input  lbcp_pkg::cmd_type              cmd,
   input  lbcp_pkg::chain_type            chain_in,
   output lbcp_pkg::chain_type            chain_out
);

   logic [lbcp_pkg::ADDR_BITS-1:0] tag_ff, tag_in;
   logic                           valid_ff, valid_in;
   logic                           mig_ff, mig_in;
   logic                           dirty_ff, dirty_in;
   logic [lbcp_pkg::RANK_W-1:0]    rank_ff, rank_in;
   logic                           hit_ff, victim_ff, ffirst_ff, rfirst_ff, pre_ff;

   logic hit, victim, pre, ffirst, rcand, rfirst;

   always_comb begin
      hit    = valid_ff && (tag_ff == addr);
      victim = valid_ff && (rank_ff == lbcp_pkg::RANK_W'(1));
      pre    = (32'(idx) == 32'(pslot));
      ffirst = !valid_ff && !chain_in.free_seen;
      rcand  = !valid_ff || victim;
      rfirst = rcand && !chain_in.rep_seen;

      chain_out              = chain_in;
      chain_out.hit          = chain_in.hit | hit;
      chain_out.hit_mig      = chain_in.hit_mig | (hit & mig_ff);
      chain_out.hit_rank     = chain_in.hit_rank | (hit ? rank_ff : '0);
      chain_out.hit_slot     = chain_in.hit_slot | (hit ? idx : '0);
      chain_out.victim_tag   = chain_in.victim_tag | (victim ? tag_ff : '0);
      chain_out.victim_dirty = chain_in.victim_dirty | (victim & dirty_ff);
      chain_out.pre_busy     = chain_in.pre_busy | (pre & valid_ff);
      chain_out.free_seen    = chain_in.free_seen | !valid_ff;
      chain_out.free_slot    = chain_in.free_slot | (ffirst ? idx : '0);
      chain_out.rep_seen     = chain_in.rep_seen | rcand;
      chain_out.rep_slot     = chain_in.rep_slot | (rfirst ? idx : '0);
   end

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      mig_in   = mig_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      if (exec_en) begin
         if (cmd.dec_en && (rank_ff > cmd.dec_thr)) begin
            rank_in = rank_ff - lbcp_pkg::RANK_W'(1);
         end
         unique case (cmd.act)
            lbcp_pkg::ACT_TOUCH: begin
               if (hit_ff) begin
                  rank_in  = cmd.push_rank;
                  dirty_in = dirty_ff | cmd.wr;
               end
            end
            lbcp_pkg::ACT_HIT_MIG: begin
               if (hit_ff) dirty_in = dirty_ff | cmd.wr;
            end
            lbcp_pkg::ACT_NEW, lbcp_pkg::ACT_REPLACE: begin
               // The freed victim may itself be the slot taken by the new entry.
               if (cmd.act == lbcp_pkg::ACT_REPLACE && victim_ff) begin
                  valid_in = 1'b0;
                  mig_in   = 1'b0;
                  dirty_in = 1'b0;
                  rank_in  = '0;
               end
               if ((cmd.act == lbcp_pkg::ACT_NEW && ffirst_ff) ||
                   (cmd.act == lbcp_pkg::ACT_REPLACE && rfirst_ff)) begin
                  tag_in   = cmd.addr;
                  valid_in = 1'b1;
                  mig_in   = 1'b1;
                  dirty_in = cmd.wr;
                  rank_in  = '0;
               end
            end
            lbcp_pkg::ACT_MIGRATE: begin
               if (hit_ff) begin
                  mig_in  = 1'b0;
                  rank_in = cmd.push_rank;
               end
            end
            lbcp_pkg::ACT_REMOVE: begin
               if (hit_ff) begin
                  valid_in = 1'b0;
                  mig_in   = 1'b0;
                  dirty_in = 1'b0;
                  rank_in  = '0;
               end
            end
            lbcp_pkg::ACT_PRELOAD: begin
               if (pre_ff) begin
                  tag_in   = cmd.addr;
                  valid_in = 1'b1;
                  mig_in   = 1'b0;
                  dirty_in = 1'b0;
                  rank_in  = cmd.push_rank;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (reset) begin
         valid_ff  <= 1'b0;
         mig_ff    <= 1'b0;
         dirty_ff  <= 1'b0;
         rank_ff   <= '0;
         hit_ff    <= 1'b0;
         victim_ff <= 1'b0;
         ffirst_ff <= 1'b0;
         rfirst_ff <= 1'b0;
         pre_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mig_ff   <= mig_in;
         dirty_ff <= dirty_in;
         rank_ff  <= rank_in;
         if (match_en) begin
            hit_ff    <= hit;
            victim_ff <= victim;
            ffirst_ff <= ffirst;
            rfirst_ff <= rfirst;
            pre_ff    <= pre;
         end
      end
   end

endmodule

// ===== sv/lru_block_cache_policy.sv =====
// ----------------------------------------------------------------------------
// LRU block cache policy
// Fully associative LRU slot allocator built from a row of slot cells.
// ----------------------------------------------------------------------------
// Usage: the request channel (req_valid, req_stall, req_mode, req_block_addr,
// req_is_write, req_preload_slot) carries one word per operation. Every
// accepted word yields exactly one response word on the rsp_ channel (op,
// slot, evicted address and dirty mark); non-map modes answer with op 4.
// Each word passes through the match phase, where all cells compare their
// tags and a chain through the cells collects the hit, the victim and the
// lowest free slot, and then the update phase, where the cells apply the
// result and the response register is loaded. A new word is accepted only
// while the block is idle or while the previous word leaves its update
// phase. When the receiver stalls, the response register holds its word
// and the update phase of the next word waits, so req_stall rises. Reset
// clears all slots, the recency order and the counters, and sets the
// capacity to 64. The capacity register (csr_wr_en, csr_wr_data) must be
// written only between words; the block does not enforce this.
// ----------------------------------------------------------------------------
module lru_block_cache_policy (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_block_addr,
   input  logic        req_is_write,
   input  logic [5:0]  req_preload_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_op,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_evicted_addr,
   output logic        rsp_evicted_dirty
);

   localparam int N  = lbcp_pkg::NUM_SLOTS;
   localparam int RW = lbcp_pkg::RANK_W;

   lbcp_pkg::state_type state_ff, state_in;

   logic [lbcp_pkg::CAP_W-1:0]     cap_ff;
   logic [RW-1:0]                  occ_ff, occ_in;
   logic [RW-1:0]                  ord_ff, ord_in;
   lbcp_pkg::mode_type             mode_ff;
   logic [lbcp_pkg::ADDR_BITS-1:0] addr_ff;
   logic                           wr_ff;
   logic [lbcp_pkg::PSLOT_W-1:0]   pslot_ff;
   lbcp_pkg::chain_type            sum_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   lbcp_pkg::op_type               op_ff, op_in;
   logic [lbcp_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [lbcp_pkg::ADDR_BITS-1:0] ev_addr_ff, ev_addr_in;
   logic                           ev_dirty_ff, ev_dirty_in;

   lbcp_pkg::chain_type chain [0:N];
   lbcp_pkg::cmd_type   cmd;

   logic          accept, out_free, exec_go, full;
   logic [RW-1:0] eff_cap;

   assign chain[0] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      lbcp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .idx       (lbcp_pkg::SLOT_W'(i)),
         .addr      (addr_ff),
         .pslot     (pslot_ff),
         .match_en  (state_ff == lbcp_pkg::S_MATCH),
         .exec_en   (exec_go),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = RW'(1);
      end else if (int'(cap_ff) > N) begin
         eff_cap = RW'(N);
      end else begin
         eff_cap = RW'(cap_ff);
      end
      full = (occ_ff >= eff_cap);
   end

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      exec_go   = (state_ff == lbcp_pkg::S_EXEC) && out_free;
      req_stall = !((state_ff == lbcp_pkg::S_IDLE) || exec_go);
      accept    = req_valid && !req_stall;

      state_in = state_ff;
      unique case (state_ff)
         lbcp_pkg::S_IDLE:  if (accept) state_in = lbcp_pkg::S_MATCH;
         lbcp_pkg::S_MATCH: state_in = lbcp_pkg::S_EXEC;
         lbcp_pkg::S_EXEC: begin
            if (exec_go) state_in = accept ? lbcp_pkg::S_MATCH : lbcp_pkg::S_IDLE;
         end
         default: state_in = lbcp_pkg::S_IDLE;
      endcase

      cmd.act       = lbcp_pkg::ACT_NONE;
      cmd.addr      = addr_ff;
      cmd.wr        = wr_ff;
      cmd.push_rank = ord_ff + RW'(1);
      cmd.dec_en    = 1'b0;
      cmd.dec_thr   = sum_ff.hit_rank;
      occ_in        = occ_ff;
      ord_in        = ord_ff;
      op_in         = lbcp_pkg::OP_NONE;
      slot_in       = '0;
      ev_addr_in    = '0;
      ev_dirty_in   = 1'b0;

      unique case (mode_ff)
         lbcp_pkg::MODE_MAP: begin
            if (sum_ff.hit) begin
               op_in   = lbcp_pkg::OP_HIT;
               slot_in = sum_ff.hit_slot;
               if (sum_ff.hit_mig) begin
                  cmd.act = lbcp_pkg::ACT_HIT_MIG;
               end else begin
                  cmd.act       = lbcp_pkg::ACT_TOUCH;
                  cmd.dec_en    = 1'b1;
                  cmd.push_rank = ord_ff;
               end
            end else if (full && ord_ff == '0) begin
               op_in = lbcp_pkg::OP_FAIL;
            end else if (full) begin
               op_in       = lbcp_pkg::OP_REPLACE;
               cmd.act     = lbcp_pkg::ACT_REPLACE;
               cmd.dec_en  = 1'b1;
               cmd.dec_thr = RW'(1);
               slot_in     = sum_ff.rep_slot;
               ev_addr_in  = sum_ff.victim_tag;
               ev_dirty_in = sum_ff.victim_dirty;
               ord_in      = ord_ff - RW'(1);
            end else begin
               op_in   = lbcp_pkg::OP_NEW;
               cmd.act = lbcp_pkg::ACT_NEW;
               slot_in = sum_ff.free_slot;
               occ_in  = occ_ff + RW'(1);
            end
         end
         lbcp_pkg::MODE_MIGRATE: begin
            if (sum_ff.hit && sum_ff.hit_mig) begin
               cmd.act = lbcp_pkg::ACT_MIGRATE;
               ord_in  = ord_ff + RW'(1);
            end
         end
         lbcp_pkg::MODE_REMOVE: begin
            if (sum_ff.hit) begin
               cmd.act    = lbcp_pkg::ACT_REMOVE;
               cmd.dec_en = (sum_ff.hit_rank != '0);
               occ_in     = occ_ff - RW'(1);
               if (sum_ff.hit_rank != '0) ord_in = ord_ff - RW'(1);
            end
         end
         lbcp_pkg::MODE_PRELOAD: begin
            if (!sum_ff.hit && !sum_ff.pre_busy && int'(pslot_ff) < N) begin
               cmd.act = lbcp_pkg::ACT_PRELOAD;
               occ_in  = occ_ff + RW'(1);
               ord_in  = ord_ff + RW'(1);
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= lbcp_pkg::mode_type'(req_mode);
         addr_ff  <= lbcp_pkg::ADDR_BITS'(req_block_addr);
         wr_ff    <= req_is_write;
         pslot_ff <= req_preload_slot;
      end
      if (state_ff == lbcp_pkg::S_MATCH) sum_ff <= chain[N];
      if (exec_go) begin
         op_ff       <= op_in;
         slot_ff     <= slot_in;
         ev_addr_ff  <= ev_addr_in;
         ev_dirty_ff <= ev_dirty_in;
      end
      if (reset) begin
         state_ff     <= lbcp_pkg::S_IDLE;
         cap_ff       <= lbcp_pkg::CAP_W'(lbcp_pkg::CAP_RESET);
         occ_ff       <= '0;
         ord_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (exec_go) begin
            occ_ff <= occ_in;
            ord_ff <= ord_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_op            = op_ff;
   assign rsp_slot          = lbcp_pkg::OUT_SLOT_W'(slot_ff);
   assign rsp_evicted_addr  = lbcp_pkg::OUT_ADDR_W'(ev_addr_ff);
   assign rsp_evicted_dirty = ev_dirty_ff;

   a_order_within_occ: assert property (@(posedge clock) disable iff (reset)
      ord_ff <= occ_ff) else $error("recency order larger than occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= N) else $error("occupancy beyond slot count");

   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == lbcp_pkg::S_MATCH)
      else $error("accepted word did not enter match phase");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && op_ff == lbcp_pkg::OP_FAIL) |-> (slot_ff == '0 && ev_addr_ff == '0))
      else $error("fail response carries data");

endmodule

// ===== verif/lru_block_cache_policy_chk.sv =====
// ----------------------------------------------------------------------------
// LRU block cache policy checker
// Watches the request, response and capacity ports, keeps its own LRU slot
// table, predicts each response word and compares it field by field.
// ----------------------------------------------------------------------------
module lru_block_cache_policy_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_block_addr,
   input  logic        req_is_write,
   input  logic [5:0]  req_preload_slot,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_op,
   input  logic [5:0]  rsp_slot,
   input  logic [31:0] rsp_evicted_addr,
   input  logic        rsp_evicted_dirty,
   output int          fail_count,
   output int          pending_count,
   output int          hit_seen,
   output int          replace_seen,
   output int          fail_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      lbcp_pkg::op_type op;
      logic [5:0]       slot;
      logic [31:0]      ev_addr;
      logic             ev_dirty;
   } answer_type;

   logic [31:0] tag_mem [lbcp_pkg::NUM_SLOTS];
   logic        live [lbcp_pkg::NUM_SLOTS];
   logic        moving [lbcp_pkg::NUM_SLOTS];
   logic        dirty [lbcp_pkg::NUM_SLOTS];
   int          rank [lbcp_pkg::NUM_SLOTS];
   int          used;
   int          ranked;
   logic [6:0]  capacity;
   answer_type  answer_q [$];

   function automatic int lookup(logic [31:0] a);
      for (int i = 0; i < lbcp_pkg::NUM_SLOTS; i++)
         if (live[i] && tag_mem[i] == a) return i;
      return -1;
   endfunction

   function automatic void unrank(int s);
      int r;
      r = rank[s];
      if (r == 0) return;
      for (int i = 0; i < lbcp_pkg::NUM_SLOTS; i++)
         if (rank[i] > r) rank[i]--;
      rank[s] = 0;
      ranked--;
   endfunction

   function automatic void promote(int s);
      ranked++;
      rank[s] = ranked;
   endfunction

   function automatic void release_slot(int s);
      unrank(s);
      live[s] = 0;
      moving[s] = 0;
      dirty[s] = 0;
      used--;
   endfunction

   function automatic answer_type predict_lru(lbcp_pkg::mode_type m, logic [31:0] a,
                                              logic wr, logic [5:0] ps);
      answer_type ans;
      int s, v, lim;
      ans = '{lbcp_pkg::OP_NONE, 6'd0, 32'd0, 1'b0};
      s = lookup(a);
      lim = (capacity == 0) ? 1 :
            (capacity > lbcp_pkg::NUM_SLOTS) ? lbcp_pkg::NUM_SLOTS : capacity;
      unique case (m)
         lbcp_pkg::MODE_MAP: begin
            if (s >= 0) begin
               ans.op = lbcp_pkg::OP_HIT;
               if (!moving[s]) begin
                  unrank(s);
                  promote(s);
               end
            end else if (used >= lim && ranked == 0) begin
               ans.op = lbcp_pkg::OP_FAIL;
            end else begin
               ans.op = lbcp_pkg::OP_NEW;
               if (used >= lim) begin
                  ans.op = lbcp_pkg::OP_REPLACE;
                  v = 0;
                  for (int i = lbcp_pkg::NUM_SLOTS - 1; i >= 0; i--)
                     if (rank[i] == 1) v = i;
                  ans.ev_addr = tag_mem[v];
                  ans.ev_dirty = dirty[v];
                  release_slot(v);
               end
               s = 0;
               while (live[s]) s++;
               tag_mem[s] = a;
               live[s] = 1;
               moving[s] = 1;
               dirty[s] = 0;
               rank[s] = 0;
               used++;
            end
            if (ans.op != lbcp_pkg::OP_FAIL) begin
               ans.slot = s[5:0];
               if (wr) dirty[s] = 1;
            end
         end
         lbcp_pkg::MODE_MIGRATE: begin
            if (s >= 0 && moving[s]) begin
               moving[s] = 0;
               promote(s);
            end
         end
         lbcp_pkg::MODE_REMOVE: begin
            if (s >= 0) release_slot(s);
         end
         lbcp_pkg::MODE_PRELOAD: begin
            if (s < 0 && !live[ps]) begin
               tag_mem[ps] = a;
               live[ps] = 1;
               moving[ps] = 0;
               dirty[ps] = 0;
               used++;
               promote(int'(ps));
            end
         end
      endcase
      return ans;
   endfunction

   always_ff @(posedge clock) begin
      answer_type exp_ans;
      if (reset) begin
         for (int i = 0; i < lbcp_pkg::NUM_SLOTS; i++) begin
            tag_mem[i] = '0;
            live[i] = 0;
            moving[i] = 0;
            dirty[i] = 0;
            rank[i] = 0;
         end
         used = 0;
         ranked = 0;
         capacity = 7'(lbcp_pkg::CAP_RESET);
         answer_q.delete();
         fail_count <= 0;
         pending_count <= 0;
         hit_seen <= 0;
         replace_seen <= 0;
         fail_seen <= 0;
      end else begin
         // The response is checked first: the request of this edge can only
         // answer at a later edge.
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response word with none expected: op %0d slot %0d",
                        $time, rsp_op, rsp_slot);
               fail_count <= fail_count + 1;
            end else begin
               exp_ans = answer_q.pop_front();
               if (rsp_op !== exp_ans.op || rsp_slot !== exp_ans.slot ||
                   rsp_evicted_addr !== exp_ans.ev_addr ||
                   rsp_evicted_dirty !== exp_ans.ev_dirty) begin
                  $display("%0t: mismatch expected %0d %0d %h %0d actual %0d %0d %h %0d",
                           $time, exp_ans.op, exp_ans.slot, exp_ans.ev_addr,
                           exp_ans.ev_dirty, rsp_op, rsp_slot, rsp_evicted_addr,
                           rsp_evicted_dirty);
                  fail_count <= fail_count + 1;
               end
               if (exp_ans.op == lbcp_pkg::OP_HIT) hit_seen <= hit_seen + 1;
               if (exp_ans.op == lbcp_pkg::OP_REPLACE) replace_seen <= replace_seen + 1;
               if (exp_ans.op == lbcp_pkg::OP_FAIL) fail_seen <= fail_seen + 1;
            end
         end
         if (csr_wr_en) capacity = csr_wr_data;
         if (req_valid && !req_stall)
            answer_q.push_back(predict_lru(lbcp_pkg::mode_type'(req_mode),
                                           req_block_addr, req_is_write,
                                           req_preload_slot));
         pending_count <= answer_q.size();
      end
   end

endmodule

// ===== verif/lru_block_cache_policy_tb.sv =====
// ----------------------------------------------------------------------------
// LRU block cache policy testbench
// Directed and random map, migrate, remove and preload words over several
// capacities, with random idling on both channels; the checker predicts.
// ----------------------------------------------------------------------------
module lru_block_cache_policy_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [31:0] req_block_addr;
   logic        req_is_write;
   logic [5:0]  req_preload_slot;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_op;
   logic [5:0]  rsp_slot;
   logic [31:0] rsp_evicted_addr;
   logic        rsp_evicted_dirty;
   int          fail_count, pending_count;
   int          hit_seen, replace_seen, fail_seen;
   logic        calm;
   int          sent;
   logic [31:0] recent [16];

   lru_block_cache_policy dut (.*);
   lru_block_cache_policy_chk chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver stalls in bursts; none once the run is calm.
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 16);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_word(lbcp_pkg::mode_type m, logic [31:0] a, logic wr,
                            logic [5:0] ps);
      int n;
      if (!calm && $urandom_range(0, 11) == 0) begin
         n = $urandom_range(1, 16);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= m;
      req_block_addr <= a;
      req_is_write <= wr;
      req_preload_slot <= ps;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain_and_set(logic [6:0] cap);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // Addresses come mostly from a small recent pool so hits and removes land.
   function automatic logic [31:0] pick_addr();
      int k;
      k = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) begin
         recent[k] = $urandom();
         if ($urandom_range(0, 7) == 0) recent[k] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 0;
      end
      return recent[k];
   endfunction

   initial begin
      logic [6:0] caps [6];
      logic [31:0] a;
      int r;
      caps = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd4, 7'd12};
      calm = 0;
      sent = 0;
      for (int i = 0; i < 16; i++) recent[i] = $urandom();
      reset <= 1;
      csr_wr_en <= 0;
      csr_wr_data <= '0;
      req_valid <= 0;
      req_mode <= lbcp_pkg::MODE_MAP;
      req_block_addr <= '0;
      req_is_write <= 0;
      req_preload_slot <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: miss, hit on migrating entry, fail when full, migrate,
      // replace with dirty eviction, ignored events, preload cases.
      drain_and_set(7'd2);
      send_word(lbcp_pkg::MODE_MAP, 32'h0, 1, 6'd0);
      send_word(lbcp_pkg::MODE_MAP, 32'hFFFF_FFFF, 0, 6'd63);
      send_word(lbcp_pkg::MODE_MAP, 32'h0, 0, 6'd0);
      send_word(lbcp_pkg::MODE_MAP, 32'h1234_5678, 0, 6'd0);
      send_word(lbcp_pkg::MODE_MIGRATE, 32'h0, 0, 6'd0);
      send_word(lbcp_pkg::MODE_MIGRATE, 32'h0, 0, 6'd0);
      send_word(lbcp_pkg::MODE_MIGRATE, 32'h5555_5555, 0, 6'd0);
      send_word(lbcp_pkg::MODE_MAP, 32'h1234_5678, 1, 6'd0);
      send_word(lbcp_pkg::MODE_MIGRATE, 32'hFFFF_FFFF, 0, 6'd0);
      send_word(lbcp_pkg::MODE_MAP, 32'hFFFF_FFFF, 0, 6'd0);
      send_word(lbcp_pkg::MODE_REMOVE, 32'hAAAA_AAAA, 0, 6'd0);
      send_word(lbcp_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 0, 6'd0);
      send_word(lbcp_pkg::MODE_PRELOAD, 32'h1234_5678, 0, 6'd5);
      send_word(lbcp_pkg::MODE_PRELOAD, 32'h0BAD_F00D, 0, 6'd0);
      send_word(lbcp_pkg::MODE_PRELOAD, 32'h0BAD_F00D, 0, 6'd63);
      send_word(lbcp_pkg::MODE_PRELOAD, 32'h7777_7777, 1, 6'd63);
      send_word(lbcp_pkg::MODE_MAP, 32'hCAFE_0000, 1, 6'd0);
      send_word(lbcp_pkg::MODE_MAP, 32'h0BAD_F00D, 1, 6'd21);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 3) begin
            // Hold off until the block has answered everything.
            req_valid <= 0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         drain_and_set(caps[ph]);
         if (ph == 5) calm = 1;
         for (int k = 0; k < 220; k++) begin
            r = $urandom_range(0, 99);
            a = pick_addr();
            if (r < 55)
               send_word(lbcp_pkg::MODE_MAP, a, 1'($urandom()), 6'($urandom()));
            else if (r < 80)
               send_word(lbcp_pkg::MODE_MIGRATE, a, 1'($urandom()), 6'($urandom()));
            else if (r < 90)
               send_word(lbcp_pkg::MODE_REMOVE, a, 1'($urandom()), 6'($urandom()));
            else
               send_word(lbcp_pkg::MODE_PRELOAD, a, 1'($urandom()), 6'($urandom()));
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d words over capacities 1, 0, 127, 64, 4, 12 and 2.", sent);
      $display("Responses: %0d hits, %0d replacements, %0d failed misses.",
               hit_seen, replace_seen, fail_seen);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lbcp_pkg.sv
sv/lbcp_cell.sv
sv/lru_block_cache_policy.sv
verif/lru_block_cache_policy_chk.sv
verif/lru_block_cache_policy_tb.sv
